/* hw/rtl/maf_pkg.sv */
// Shared types and constants for the moving-average filter.
`timescale 1ns / 1ps

package maf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WIN_W    = 9;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 9'd100;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SETUP,
    ST_DIV,
    ST_OUT
  } maf_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;    // latch the sample, read the oldest slot
    logic update;    // update running sum, ring and index
    logic setup;     // load divider with |sum|
    logic step;      // one restoring division step
    logic out_load;  // move result into output register
  } maf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pass;      // effective window is zero
    logic out_free;  // output register can take a word this cycle
  } maf_sts_t;

endpackage

/* hw/rtl/moving_average_filter_unit.sv */
// Top level of the moving-average filter: controller plus datapath.
//
//   Channel  Dir  Handshake                   Payload
//   s_axis   in   s_axis_tvalid/tready        tdata[15:0] = sample
//   m_axis   out  m_axis_tvalid/tready        tdata[15:0] = average
//   cfg      in   cfg_valid/cfg_ready         cfg_data[8:0] = window_length
//
// Each word passes accept, update, divider setup, the one-bit-per-cycle
// restoring divider and the output load; with a window of zero the sample
// goes from accept straight to output load. One word is in flight at a time.
// The result waits in an output register, so the next word is accepted while
// it stalls. Reset and any window write clear sum, index and wrap flag at once
// (no clearing pass), so old ring slots read as zero; window defaults to 100.
`timescale 1ns / 1ps

module moving_average_filter_unit #(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] average
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i
);
  import maf_pkg::*;

  localparam int unsigned DIV_STEPS = SAMPLE_W + $clog2(DEPTH);

  maf_cmd_t cmd;
  maf_sts_t sts;
  logic signed [SAMPLE_W-1:0] avg;

  assign cfg_ready_o = 1'b1;

  maf_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  maf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_wr_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (avg)
  );

  assign m_axis_tdata_o = avg;

endmodule

/* hw/rtl/maf_ctrl.sv */
// Sequencer for the moving-average filter: accept, update, divide, emit.
`timescale 1ns / 1ps

module maf_ctrl #(
  parameter int unsigned DIV_STEPS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  maf_pkg::maf_sts_t sts_i,
  output maf_pkg::maf_cmd_t cmd_o
);
  import maf_pkg::*;

  localparam int unsigned CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  maf_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign accept = s_valid_i && s_ready_o;

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.pass ? ST_OUT : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        cnt_d       = CNT_W'(DIV_STEPS - 1);
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // An accepted word always starts either the update or the pass-through path
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_UPDATE || state_q == ST_OUT))
    else $error("maf_ctrl: bad state after accept");
`endif

endmodule

/* hw/rtl/maf_dp.sv */
// Datapath: sample ring, running sum, window register, divider, output register.
`timescale 1ns / 1ps

module maf_dp #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  maf_pkg::maf_cmd_t          cmd_i,
  output maf_pkg::maf_sts_t          sts_o,
  input  logic                       cfg_wr_i,
  input  logic [maf_pkg::WIN_W-1:0]  cfg_data_i,
  input  logic signed [maf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [maf_pkg::SAMPLE_W-1:0] out_data_o
);
  import maf_pkg::*;

  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned SUM_W     = SAMPLE_W + IDX_W;
  localparam int unsigned CMP_W     = (IDX_W + 1 > WIN_W) ? IDX_W + 1 : WIN_W;
  localparam int unsigned DEPTH_CAP = (DEPTH > 511) ? 511 : DEPTH;
  localparam logic [WIN_W-1:0] DEPTH_LIM = WIN_W'(DEPTH_CAP);

  logic [WIN_W-1:0]          window_q;
  logic [WIN_W-1:0]          p_eff;
  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] old_smp;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [CMP_W-1:0]          idx_inc;
  logic                      wrap;
  logic                      full_q;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [SUM_W-1:0]          quo_q, quo_neg, mag;
  logic [WIN_W-1:0]          rem_q, rem_d;
  logic [WIN_W:0]            rem_sh, rem_sub;
  logic                      rem_ge;
  logic                      neg_q;
  logic                      out_valid_q;
  logic signed [SAMPLE_W-1:0] out_q, result;

  // Window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_wr_i) begin
      window_q <= cfg_data_i;
    end
  end

  assign p_eff = (window_q > DEPTH_LIM) ? DEPTH_LIM : window_q;

  // Ring memory: read oldest slot on accept, write new sample on update
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q     <= mem[idx_q];
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem[idx_q] <= sample_q;
    end
  end

  // Slots are written in order from zero after a clear, so until the first
  // wrap the slot at the index has not been written and counts as zero.
  assign old_smp = full_q ? rd_q : '0;
  assign idx_inc = CMP_W'(idx_q) + 1'b1;
  assign wrap    = (idx_inc == CMP_W'(p_eff));
  assign idx_d   = wrap ? '0 : idx_inc[IDX_W-1:0];
  assign sum_d   = sum_q
                 - {{(SUM_W-SAMPLE_W){old_smp[SAMPLE_W-1]}}, old_smp}
                 + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};

  // History state: index, wrap flag, running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      full_q <= 1'b0;
      sum_q  <= '0;
    end else if (cfg_wr_i) begin
      idx_q  <= '0;
      full_q <= 1'b0;
      sum_q  <= '0;
    end else if (cmd_i.update) begin
      idx_q <= idx_d;
      sum_q <= sum_d;
      if (wrap) begin
        full_q <= 1'b1;
      end
    end
  end

  // Restoring divider: |sum| / p, one quotient bit per step
  assign mag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, p_eff};
  assign rem_ge  = (rem_sh >= {1'b0, p_eff});
  assign rem_d   = rem_ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      quo_q <= mag;
      rem_q <= '0;
      neg_q <= sum_q[SUM_W-1];
    end else if (cmd_i.step) begin
      quo_q <= {quo_q[SUM_W-2:0], rem_ge};
      rem_q <= rem_d;
    end
  end

  // Signed result, truncated toward zero; the sample itself when the window is zero
  assign quo_neg = -quo_q;
  assign result  = sts_o.pass ? sample_q
                 : (neg_q ? quo_neg[SAMPLE_W-1:0] : quo_q[SAMPLE_W-1:0]);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
  assign sts_o.pass     = (p_eff == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

`ifndef SYNTH
  // Write index stays inside the active window
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_eff != '0) |-> (CMP_W'(idx_q) < CMP_W'(p_eff)))
    else $error("maf_dp: write index outside window");

  // A result is never loaded over a word still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("maf_dp: output register overwritten");

  // A loaded result is presented on the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("maf_dp: loaded word not presented");
`endif

endmodule
